// ===== design/fcm_pkg.sv =====
// Package for the frontier cell mask block: item types, window cell and
// line-memory word types, register indexes and cell codes. No dependencies.
package fcm_pkg;

  localparam int APB_AW = 3;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic REQ_CELL  = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam logic signed [7:0] OCC_FREE    = 8'sd0;
  localparam logic signed [7:0] OCC_UNKNOWN = -8'sd1;

  // columns held in the horizontal window
  localparam int WIN = 3;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = 2;
  localparam int OUT_CW    = 3;

  typedef struct packed {
    logic              req_type;
    logic signed [7:0] occupancy;
    logic              allowed;
  } in_item_t;

  typedef struct packed {
    logic       frontier;
    logic [9:0] cell_row;
    logic [9:0] cell_col;
    logic       frame_last;
  } out_item_t;

  // one column of the 3x3 window: vertical unknown OR, candidate, column 0 flag
  typedef struct packed {
    logic v;
    logic cand;
    logic first;
  } cell_t;

  // per-column line memory word: unknown bits of the two latest rows, candidate
  typedef struct packed {
    logic u_old;
    logic u_new;
    logic cand;
  } line_word_t;

endpackage

// ===== design/fcm_line_mem.sv =====
// Column line memory: one word per grid column, registered read with
// write-through on a same-address write. Depends on fcm_pkg.
module fcm_line_mem #(
  parameter int DEPTH = 1024
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr_i,
  output fcm_pkg::line_word_t        rd_data_o,
  input  logic                       wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  fcm_pkg::line_word_t        wr_data_i
);
  import fcm_pkg::*;

  line_word_t mem_q [DEPTH];
  line_word_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= (wr_en_i && (wr_addr_i == rd_addr_i)) ? wr_data_i : mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== design/fcm_cell.sv =====
// One column cell of the horizontal window chain; loads from its neighbor
// on each feed. Depends on fcm_pkg.
module fcm_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  fcm_pkg::cell_t d_i,
  output fcm_pkg::cell_t q_o
);
  import fcm_pkg::*;

  cell_t cell_q;
  cell_t cell_d;

  always_comb begin
    cell_d = cell_q;
    if (shift_i) begin
      cell_d = d_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

// ===== design/fcm_out_buf.sv =====
// Result buffer: small FIFO that decouples the window pipeline from the
// output channel. Depends on fcm_pkg.
module fcm_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fcm_pkg::out_item_t push_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fcm_pkg::out_item_t out_item_o
);
  import fcm_pkg::*;

  out_item_t           slot_q [OUT_DEPTH];
  logic [OUT_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [OUT_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [OUT_CW-1:0]   cnt_q, cnt_d;
  logic                pop;

  always_comb begin
    pop      = (cnt_q != '0) && !out_stall_i;
    wr_ptr_d = push_i ? wr_ptr_q + OUT_AW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + OUT_AW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + OUT_CW'(push_i) - OUT_CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = slot_q[rd_ptr_q];

endmodule

// ===== design/frontier_cell_mask_unit.sv =====
// Frontier cell mask, top level: position counters, column line memory,
// window cell chain and result buffer. Depends on fcm_pkg, fcm_line_mem,
// fcm_cell and fcm_out_buf.
//
// Usage: grid cells enter in raster order on the in channel (valid/stall),
// one per clock unless stalled. The result for a cell leaves on the out
// channel once the cell one row and one column past it has been taken; at
// the end of a frame one drain item per pending result flushes the rest.
// Results come out in order via the stage 1, stage 2 and buffer registers.
// Throughput: one item per clock unless stalled; the column memory, read
// and written once per item, has separate read and write ports. A one-row
// frame holds off the input for one cycle after its last cell. The user is
// to write the frame size over the APB port only while idle; the block does
// not enforce it; a write restarts the frame. Reset restarts it at 1024 x
// 1024 (capped by the maximum). If the receiver stalls, up to four results
// are buffered; after that the input is stalled until results are taken.
module frontier_cell_mask_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  fcm_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output fcm_pkg::out_item_t          out_item_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fcm_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fcm_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int LW    = $clog2(MAX_WIDTH + 2);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 2);
  localparam int OW    = $clog2(MAX_HEIGHT);
  localparam int W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int H_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

  typedef struct packed {
    logic       feed;
    logic       wr;
    logic       emit;
    logic       unk;
    logic       cand;
    logic       has_old;
    logic       has_new;
    logic       first;
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
  } s1_t;

  typedef struct packed {
    logic       emit;
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
  } s2_t;

  logic [10:0]       fw_q, fw_d, fh_q, fh_d;
  logic [WW-1:0]     w_q, w_d;
  logic [HW-1:0]     h_q, h_d;
  logic [CW-1:0]     fc_q, fc_d, oc_q, oc_d;
  logic [RW-1:0]     fr_q, fr_d;
  logic [OW-1:0]     or_q, or_d;
  logic [LW-1:0]     lag_q, lag_d;
  logic              inject_q, inject_d;
  logic [OUT_CW-1:0] pend_q, pend_d;
  logic [CW-1:0]     s1_addr_q, s1_addr_d;
  s1_t               s1_q, s1_d;
  s2_t               s2_q, s2_d;

  logic              cfg_wr;
  logic [CW-1:0]     w_last;
  logic [OW-1:0]     h_last;
  logic              in_done, acc, is_drain, feed_real, drain_hit, feed, emit;
  logic              frame_end, fc_wrap, pop;

  line_word_t        rd_word, wr_word;
  logic              wr_en;
  cell_t             cell_in;
  cell_t             win_d [WIN];
  cell_t             win   [WIN];
  out_item_t         push_item;

  // ---- configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = {21'b0, fw_q};
      REG_FRAME_HEIGHT: prdata = {21'b0, fh_q};
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    fw_d = fw_q;
    fh_d = fh_q;
    w_d  = w_q;
    h_d  = h_q;
    if (cfg_wr) begin
      case (paddr[2])
        REG_FRAME_WIDTH: begin
          fw_d = pwdata[10:0];
          if (pwdata[10:0] == 11'd0) begin
            w_d = WW'(1);
          end else if (32'(pwdata[10:0]) > MAX_WIDTH) begin
            w_d = WW'(MAX_WIDTH);
          end else begin
            w_d = WW'(pwdata[10:0]);
          end
        end
        REG_FRAME_HEIGHT: begin
          fh_d = pwdata[10:0];
          if (pwdata[10:0] == 11'd0) begin
            h_d = HW'(1);
          end else if (32'(pwdata[10:0]) > MAX_HEIGHT) begin
            h_d = HW'(MAX_HEIGHT);
          end else begin
            h_d = HW'(pwdata[10:0]);
          end
        end
        default: begin
          fw_d = fw_q;
        end
      endcase
    end
  end

  // ---- position control
  always_comb begin
    w_last    = CW'(w_q - WW'(1));
    h_last    = OW'(h_q - HW'(1));
    in_done   = (fr_q >= RW'(h_q));
    acc       = in_valid_i && !in_stall_o;
    is_drain  = (in_item_i.req_type == REQ_DRAIN);
    feed_real = acc && !is_drain && !in_done;
    drain_hit = acc && is_drain && in_done;
    // drains act as cells of the row below the frame
    feed      = feed_real || drain_hit || inject_q;
    emit      = drain_hit || (feed_real && (lag_q >= LW'(w_q) + LW'(1)));
    frame_end = emit && (or_q == h_last) && (oc_q == w_last);
    fc_wrap   = (fc_q == w_last);
    pop       = out_valid_o && !out_stall_i;

    fc_d     = fc_q;
    fr_d     = fr_q;
    oc_d     = oc_q;
    or_d     = or_q;
    lag_d    = lag_q;
    // one-row frame: one extra feed so the window leads the first drain
    inject_d = feed_real && (h_q == HW'(1)) && fc_wrap;

    if (feed) begin
      if (fc_wrap) begin
        fc_d = '0;
        fr_d = fr_q + RW'(1);
      end else begin
        fc_d = fc_q + CW'(1);
      end
    end
    if (feed_real && !emit) begin
      lag_d = lag_q + LW'(1);
    end
    if (emit) begin
      if (oc_q == w_last) begin
        oc_d = '0;
        or_d = or_q + OW'(1);
      end else begin
        oc_d = oc_q + CW'(1);
      end
    end
    if (frame_end || cfg_wr) begin
      fc_d     = '0;
      fr_d     = '0;
      oc_d     = '0;
      or_d     = '0;
      lag_d    = '0;
      inject_d = 1'b0;
    end

    pend_d = pend_q + OUT_CW'(emit) - OUT_CW'(pop);
  end

  assign in_stall_o = inject_q || (pend_q == OUT_CW'(OUT_DEPTH));

  always_comb begin
    s1_d.feed    = feed;
    s1_d.wr      = feed_real;
    s1_d.emit    = emit;
    s1_d.unk     = feed_real && (in_item_i.occupancy == OCC_UNKNOWN);
    s1_d.cand    = feed_real && (in_item_i.occupancy == OCC_FREE) && in_item_i.allowed;
    s1_d.has_old = (fr_q >= RW'(2));
    s1_d.has_new = (fr_q != '0);
    s1_d.first   = (fc_q == '0);
    s1_d.row     = 10'(or_q);
    s1_d.col     = 10'(oc_q);
    s1_d.last    = frame_end;
    s1_addr_d    = feed ? fc_q : s1_addr_q;
  end

  // ---- stage 1: vertical OR from the column memory
  fcm_line_mem #(
    .DEPTH(MAX_WIDTH)
  ) u_line_mem (
    .clk_i    (clk_i),
    .rd_en_i  (feed),
    .rd_addr_i(fc_q),
    .rd_data_o(rd_word),
    .wr_en_i  (wr_en),
    .wr_addr_i(s1_addr_q),
    .wr_data_i(wr_word)
  );

  always_comb begin
    wr_en         = s1_q.feed && s1_q.wr;
    wr_word.u_old = rd_word.u_new;
    wr_word.u_new = s1_q.unk;
    wr_word.cand  = s1_q.cand;
    cell_in.v     = (s1_q.has_old && rd_word.u_old) ||
                    (s1_q.has_new && rd_word.u_new) || s1_q.unk;
    cell_in.cand  = s1_q.has_new && rd_word.cand;
    cell_in.first = s1_q.first;
    s2_d.emit     = s1_q.emit;
    s2_d.row      = s1_q.row;
    s2_d.col      = s1_q.col;
    s2_d.last     = s1_q.last;
  end

  // ---- window chain: win[0] right, win[1] center, win[2] left
  assign win_d[0] = cell_in;

  genvar k;
  for (k = 1; k < WIN; k++) begin : g_link
    assign win_d[k] = win[k-1];
  end

  for (k = 0; k < WIN; k++) begin : g_cell
    fcm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(s1_q.feed),
      .d_i    (win_d[k]),
      .q_o    (win[k])
    );
  end

  // ---- stage 2: horizontal OR with column edge masking
  always_comb begin
    push_item.frontier   = win[1].cand &&
                           (win[1].v || (win[2].v && !win[1].first) ||
                            (win[0].v && !win[0].first));
    push_item.cell_row   = s2_q.row;
    push_item.cell_col   = s2_q.col;
    push_item.frame_last = s2_q.last;
  end

  fcm_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s2_q.emit),
    .push_item_i(push_item),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // ---- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q     <= 11'(1024);
      fh_q     <= 11'(1024);
      w_q      <= WW'(W_RST);
      h_q      <= HW'(H_RST);
      fc_q     <= '0;
      fr_q     <= '0;
      oc_q     <= '0;
      or_q     <= '0;
      lag_q    <= '0;
      inject_q <= 1'b0;
      pend_q   <= '0;
      s1_q     <= '0;
      s2_q     <= '0;
    end else begin
      fw_q     <= fw_d;
      fh_q     <= fh_d;
      w_q      <= w_d;
      h_q      <= h_d;
      fc_q     <= fc_d;
      fr_q     <= fr_d;
      oc_q     <= oc_d;
      or_q     <= or_d;
      lag_q    <= lag_d;
      inject_q <= inject_d;
      pend_q   <= pend_d;
      s1_q     <= s1_d;
      s2_q     <= s2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= s1_addr_d;
  end

  // ---- assertions
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= OUT_CW'(OUT_DEPTH))
    else $error("result credits exceed buffer depth");

  a_inject_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inject_q |=> !inject_q)
    else $error("extra feed lasted more than one cycle");

  a_lag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lag_q <= LW'(w_q) + LW'(1))
    else $error("cell lag beyond one row plus one");

  a_emit_feeds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q.emit |-> s1_q.feed)
    else $error("result without a window feed");

endmodule
